FILE: rtl/double_ended_queue_with_search_unit_assert.svh
// assertion macros shared by the deque modules
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DEQS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication, disabled during reset
`define DEQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

FILE: rtl/deqs_pkg.sv
package deqs_pkg;

  // operation codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_CONTAINS   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       search_start;
    logic       search_step;
    logic       report;
    logic [1:0] status_code;
  } deqs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       hit;
    logic       last;
  } deqs_stat_t;

endpackage

FILE: rtl/deqs_ram.sv
module deqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/deqs_dp.sv
`include "double_ended_queue_with_search_unit_assert.svh"

module deqs_dp import deqs_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int COORD_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  deqs_cmd_t  cmd,
  output deqs_stat_t stat,
  input  logic [2:0] func,
  input  logic [7:0] item_x,
  input  logic [7:0] item_y,
  output logic [7:0] out_x,
  output logic [7:0] out_y,
  output logic       found,
  output logic       is_empty,
  output logic [8:0] entry_count,
  output logic [1:0] status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = COORD_BITS;
  localparam int DW    = 2 * COORD_BITS;
  localparam logic [IDX_W-1:0] CAP_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] count;
  logic [2:0]       req_func;
  logic [DW-1:0]    key;
  logic [IDX_W-1:0] scan_slot;
  logic [CNT_W-1:0] scan_left;
  logic [1:0]       res_status;
  logic             res_found;
  logic             res_pop;

  logic [31:0]      x_ext;
  logic [31:0]      y_ext;
  logic [31:0]      px_ext;
  logic [31:0]      py_ext;
  logic [31:0]      cnt_ext;
  logic [CNT_W-1:0] ring_off;
  logic [CNT_W:0]   ring_sum;
  logic [CNT_W:0]   ring_wrap;
  logic [IDX_W-1:0] ring_slot;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] scan_inc;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [DW-1:0]    ram_rdata;

  // coordinates trimmed or extended to the stored width
  assign x_ext = 32'(item_x);
  assign y_ext = 32'(item_y);

  // ring slot at front plus offset, offset below capacity
  assign ring_off  = cmd.pop_back ? count - 1'b1 : count;
  assign ring_sum  = (CNT_W + 1)'(front) + (CNT_W + 1)'(ring_off);
  assign ring_wrap = (ring_sum >= CAP_EXT) ? ring_sum - CAP_EXT : ring_sum;
  assign ring_slot = ring_wrap[IDX_W-1:0];

  assign front_dec = (front == '0) ? CAP_LAST : front - 1'b1;
  assign front_inc = (front == CAP_LAST) ? '0 : front + 1'b1;
  assign scan_inc  = (scan_slot == CAP_LAST) ? '0 : scan_slot + 1'b1;

  // memory port steering
  assign ram_we    = cmd.push_front | cmd.push_back;
  assign ram_waddr = cmd.push_front ? front_dec : ring_slot;
  assign ram_re    = cmd.pop_front | cmd.pop_back | cmd.search_start | cmd.search_step;
  always_comb begin
    if (cmd.pop_back) begin
      ram_raddr = ring_slot;
    end else if (cmd.search_step) begin
      ram_raddr = scan_slot;
    end else begin
      ram_raddr = front;
    end
  end

  deqs_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status back to the controller
  assign stat.func  = req_func;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CAP_CNT);
  assign stat.hit   = (ram_rdata == key);
  assign stat.last  = (scan_left == CNT_W'(1));

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front) begin
        front <= front_dec;
        count <= count + 1'b1;
      end else if (cmd.push_back) begin
        count <= count + 1'b1;
      end else if (cmd.pop_front) begin
        front <= front_inc;
        count <= count - 1'b1;
      end else if (cmd.pop_back) begin
        count <= count - 1'b1;
      end
    end
  end

  // request, scan and result bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func;
      key       <= {y_ext[CW-1:0], x_ext[CW-1:0]};
      res_found <= 1'b0;
    end
    if (cmd.exec) begin
      res_status <= cmd.status_code;
      res_pop    <= cmd.pop_front | cmd.pop_back;
    end
    if (cmd.search_start) begin
      scan_slot <= front_inc;
      scan_left <= count;
    end else if (cmd.search_step) begin
      scan_slot <= scan_inc;
      scan_left <= scan_left - 1'b1;
      res_found <= stat.hit;
    end
  end

  // result registers
  assign px_ext  = 32'(ram_rdata[CW-1:0]);
  assign py_ext  = 32'(ram_rdata[DW-1:CW]);
  assign cnt_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_x       <= res_pop ? px_ext[7:0] : 8'd0;
      out_y       <= res_pop ? py_ext[7:0] : 8'd0;
      found       <= res_found;
      is_empty    <= (count == '0);
      entry_count <= cnt_ext[8:0];
      status      <= res_status;
    end
  end

  `DEQS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CAP_CNT)
  `DEQS_ASSERT_NOW(a_push_room, clk, rst, cmd.push_front || cmd.push_back, count < CAP_CNT)
  `DEQS_ASSERT_NEXT(a_pop_count, clk, rst, cmd.pop_front || cmd.pop_back,
                    count == $past(count) - 1'b1)

endmodule

FILE: rtl/deqs_ctrl.sv
`include "double_ended_queue_with_search_unit_assert.svh"

module deqs_ctrl import deqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output deqs_cmd_t  cmd,
  input  deqs_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_REPORT;
        case (stat.func)
          FN_PUSH_FRONT: begin
            if (stat.full) cmd.status_code = ST_PUSH_FULL;
            else           cmd.push_front  = 1'b1;
          end
          FN_PUSH_BACK: begin
            if (stat.full) cmd.status_code = ST_PUSH_FULL;
            else           cmd.push_back   = 1'b1;
          end
          FN_POP_FRONT: begin
            if (stat.empty) cmd.status_code = ST_POP_EMPTY;
            else            cmd.pop_front   = 1'b1;
          end
          FN_POP_BACK: begin
            if (stat.empty) cmd.status_code = ST_POP_EMPTY;
            else            cmd.pop_back    = 1'b1;
          end
          FN_CONTAINS: begin
            if (!stat.empty) begin
              cmd.search_start = 1'b1;
              state_next       = S_SEARCH;
            end
          end
          default: begin
            cmd.status_code = ST_OK;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.hit || stat.last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_REPORT);
    end
  end

  `DEQS_ASSERT_NEXT(a_report_strobe, clk, rst, state == S_REPORT, done && !busy)
  `DEQS_ASSERT_NEXT(a_search_exit, clk, rst, state == S_SEARCH && (stat.hit || stat.last),
                    state == S_REPORT)
  `DEQS_ASSERT_NEXT(a_single_strobe, clk, rst, done, !done)

endmodule

FILE: rtl/double_ended_queue_with_search_unit.sv
// push and pop: start is loaded in S_IDLE, run in S_EXEC, then S_REPORT; the result strobe is registered after S_REPORT
// contains: if not empty, S_SEARCH follows S_EXEC, comparing n entries (at most CAPACITY), one per memory read
// throughput: a new start is taken in the cycle the previous result strobes
// the single read port of the entry memory sets the search rate
// reset: synchronous; queue becomes empty, memory contents are not cleared
module double_ended_queue_with_search_unit import deqs_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int COORD_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] func,
  input  logic [7:0] item_x,
  input  logic [7:0] item_y,
  output logic       done,
  output logic [7:0] out_x,
  output logic [7:0] out_y,
  output logic       found,
  output logic       is_empty,
  output logic [8:0] entry_count,
  output logic [1:0] status
);

  deqs_cmd_t  cmd;
  deqs_stat_t stat;

  // sequencing
  deqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // ring storage and result registers
  deqs_dp #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .item_x      (item_x),
    .item_y      (item_y),
    .out_x       (out_x),
    .out_y       (out_y),
    .found       (found),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule
